FILE: src/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and codes for the RGBC colour classifier.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    // input op codes
    localparam logic OP_ID   = 1'b0;
    localparam logic OP_CHAN = 1'b1;

    // result kinds
    localparam logic KIND_COLOUR = 1'b0;
    localparam logic KIND_ID     = 1'b1;

    // colour classes
    localparam logic [2:0] CLS_RED     = 3'd0;
    localparam logic [2:0] CLS_BLUE    = 3'd1;
    localparam logic [2:0] CLS_GREEN   = 3'd2;
    localparam logic [2:0] CLS_BLACK   = 3'd3;
    localparam logic [2:0] CLS_WHITE   = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_LOW_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_WHITE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_EXPECTED_ID     = 2'd2;

    localparam logic [7:0] RST_LOW_THRESHOLD   = 8'd100;
    localparam logic [7:0] RST_WHITE_THRESHOLD = 8'd150;
    localparam logic [7:0] RST_EXPECTED_ID     = 8'h44;

    // queue depths (powers of two)
    localparam int TASK_DEPTH = 4;
    localparam int OUT_DEPTH  = 4;

    // width of one result word: kind, class, fault
    localparam int RES_W = 5;

    typedef enum logic [1:0] {
        PH_CLEAR,
        PH_RED,
        PH_GREEN,
        PH_BLUE
    } t_phase;

    typedef struct packed {
        logic [7:0] low_threshold;
        logic [7:0] white_threshold;
        logic [7:0] expected_id;
    } t_cfg;

endpackage

FILE: src/rgbc_fifo.sv
// ----------------------------------------------------------------------------
// rgbc_fifo
// Small register queue with show-ahead read; push ignored when full.
// ----------------------------------------------------------------------------
module rgbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = wr_en ? AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_en ? AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: src/rgbc_front.sv
// ----------------------------------------------------------------------------
// rgbc_front
// Sequences channel readings, checks identity words and issues work entries.
// ----------------------------------------------------------------------------
module rgbc_front
    import rgbc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int TASK_W = 2 + 4 * CHANNEL_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [15:0]       i_reading,
    output logic              o_task_v,
    output logic [TASK_W-1:0] o_task
);
    localparam int CB = CHANNEL_BITS;

    t_phase          r_phase, n_phase;
    logic            r_halted, n_halted;
    logic [CB-1:0]   r_clear, r_red, r_green;
    logic [CB-1:0]   chan;
    logic            fault;

    assign chan  = i_reading[CB-1:0];
    assign fault = (i_reading[7:0] != i_cfg.expected_id);

    always_comb begin
        n_phase  = r_phase;
        n_halted = r_halted;
        o_task_v = 1'b0;
        o_task   = {KIND_COLOUR, 1'b0, r_clear, r_red, r_green, chan};
        if (i_accept && !r_halted) begin
            if (i_op == OP_ID) begin
                o_task_v = 1'b1;
                o_task   = {KIND_ID, fault, {(4*CB){1'b0}}};
                n_halted = fault;
            end else begin
                case (r_phase)
                    PH_CLEAR: n_phase = PH_RED;
                    PH_RED:   n_phase = PH_GREEN;
                    PH_GREEN: n_phase = PH_BLUE;
                    PH_BLUE: begin
                        n_phase  = PH_CLEAR;
                        o_task_v = 1'b1;
                    end
                    default:  n_phase = PH_CLEAR;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CLEAR;
            r_halted <= 1'b0;
            r_clear  <= '0;
            r_red    <= '0;
            r_green  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            if (i_accept && !r_halted && i_op == OP_CHAN) begin
                if (r_phase == PH_CLEAR) r_clear <= chan;
                if (r_phase == PH_RED)   r_red   <= chan;
                if (r_phase == PH_GREEN) r_green <= chan;
            end
        end
    end

endmodule

FILE: src/rgbc_back.sv
// ----------------------------------------------------------------------------
// rgbc_back
// Two-stage classifier: scaled products, then strict compares and class pick.
// ----------------------------------------------------------------------------
module rgbc_back
    import rgbc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int TASK_W = 2 + 4 * CHANNEL_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_task_v,
    input  logic [TASK_W-1:0] i_task,
    output logic              o_task_pop,
    input  logic              i_res_full,
    output logic              o_res_v,
    output logic [RES_W-1:0]  o_res
);
    localparam int CB = CHANNEL_BITS;
    localparam int PW = CB + 8;

    logic          t_kind, t_fault;
    logic [CB-1:0] t_c, t_r, t_g, t_b;
    logic          advance;

    logic          r_s1_v;
    logic          r_kind, r_fault, r_czero;
    logic [PW-1:0] r_rs, r_gs, r_bs, r_pl, r_pw;

    logic rh, gh, bh, rl, gl, bl, rw, gw, bw, lo_nz;
    logic [2:0] cls;

    assign {t_kind, t_fault, t_c, t_r, t_g, t_b} = i_task;

    assign advance    = !r_s1_v || !i_res_full;
    assign o_task_pop = i_task_v && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (advance) begin
            r_s1_v <= i_task_v;
        end
    end

    // x*255 as shift and subtract, threshold times clear as one small multiply
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind  <= t_kind;
            r_fault <= t_fault;
            r_czero <= (t_c == '0);
            r_rs    <= (PW'(t_r) << 8) - PW'(t_r);
            r_gs    <= (PW'(t_g) << 8) - PW'(t_g);
            r_bs    <= (PW'(t_b) << 8) - PW'(t_b);
            r_pl    <= PW'(i_cfg.low_threshold) * PW'(t_c);
            r_pw    <= PW'(i_cfg.white_threshold) * PW'(t_c);
        end
    end

    // with a zero clear every level is zero
    always_comb begin
        lo_nz = (i_cfg.low_threshold != 8'd0);
        rh = !r_czero && (r_rs > r_pl);
        gh = !r_czero && (r_gs > r_pl);
        bh = !r_czero && (r_bs > r_pl);
        rl = r_czero ? lo_nz : (r_rs < r_pl);
        gl = r_czero ? lo_nz : (r_gs < r_pl);
        bl = r_czero ? lo_nz : (r_bs < r_pl);
        rw = !r_czero && (r_rs > r_pw);
        gw = !r_czero && (r_gs > r_pw);
        bw = !r_czero && (r_bs > r_pw);
        if (rh && gl && bl) begin
            cls = CLS_RED;
        end else if (rl && gl && bh) begin
            cls = CLS_BLUE;
        end else if (rl && gh && bl) begin
            cls = CLS_GREEN;
        end else if (rl && gl && bl) begin
            cls = CLS_BLACK;
        end else if (rw && gw && bw) begin
            cls = CLS_WHITE;
        end else begin
            cls = CLS_UNKNOWN;
        end
    end

    assign o_res_v = r_s1_v && !i_res_full;
    assign o_res   = (r_kind == KIND_ID) ? {KIND_ID, CLS_RED, r_fault}
                                         : {KIND_COLOUR, cls, 1'b0};

endmodule

FILE: src/rgbc_colour_classifier.sv
// ----------------------------------------------------------------------------
// rgbc_colour_classifier
// Classifies clear/red/green/blue sensor words into a colour class and
// checks the sensor identity byte.
//
//   channel   direction  handshake                 words
//   input     in         push / full               i_op, i_reading
//   result    out        empty / pop               o_kind, o_colour_class, o_id_fault
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word is taken every cycle while full is low. A result reaches the
// output queue head after passing through the work queue, the product
// register of the classifier and the output queue. Synchronous active-low
// reset loads thresholds 100 / 150, id 0x44 and empties both queues. A
// stalled result side fills the output queue, then the classifier, then
// the work queue, and only then raises full.
// ----------------------------------------------------------------------------
module rgbc_colour_classifier
    import rgbc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [15:0] i_reading,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [2:0]  o_colour_class,
    output logic        o_id_fault,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int TASK_W = 2 + 4 * CHANNEL_BITS;

    t_cfg              r_cfg;
    logic              accept;
    logic              task_wv, task_v, task_full, task_empty, task_pop;
    logic [TASK_W-1:0] task_wdata, task_rdata;
    logic              res_v, res_full;
    logic [RES_W-1:0]  res_wdata, res_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold   <= RST_LOW_THRESHOLD;
            r_cfg.white_threshold <= RST_WHITE_THRESHOLD;
            r_cfg.expected_id     <= RST_EXPECTED_ID;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_THRESHOLD:   r_cfg.low_threshold   <= i_cfg_data;
                REG_WHITE_THRESHOLD: r_cfg.white_threshold <= i_cfg_data;
                REG_EXPECTED_ID:     r_cfg.expected_id     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full   = task_full;
    assign accept = push && !task_full;

    rgbc_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .TASK_W       (TASK_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_op      (i_op),
        .i_reading (i_reading),
        .o_task_v  (task_wv),
        .o_task    (task_wdata)
    );

    rgbc_fifo #(
        .WIDTH (TASK_W),
        .DEPTH (TASK_DEPTH)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_wv),
        .i_wdata (task_wdata),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_rdata (task_rdata),
        .o_empty (task_empty)
    );

    assign task_v = !task_empty;

    rgbc_back #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .TASK_W       (TASK_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_task_v   (task_v),
        .i_task     (task_rdata),
        .o_task_pop (task_pop),
        .i_res_full (res_full),
        .o_res_v    (res_v),
        .o_res      (res_wdata)
    );

    rgbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_v),
        .i_wdata (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign {o_kind, o_colour_class, o_id_fault} = res_rdata;

endmodule
